// File: hdl/edsu_pkg.sv
// shared types and constants for the event deadline scheduler
package edsu_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 4;
    localparam int TIME_W = 64;
    localparam int PARAM_W = 32;
    localparam int STEP_W = 32;
    localparam int NEXT_EV_W = 5;

    localparam logic [TIME_W-1:0] NO_DEADLINE = {TIME_W{1'b1}};

    // input operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SCHEDULE = 2'd0,
        FUNC_CANCEL   = 2'd1,
        FUNC_ADVANCE  = 2'd2,
        FUNC_RESERVED = 2'd3
    } func_t;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    // one table entry as held in memory
    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [PARAM_W-1:0] param;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_STAT  = 4'b1000
    } state_t;

endpackage

// File: hdl/event_deadline_scheduler_unit.sv
// top level of the earliest deadline event timer table
//
// event table with cached earliest armed deadline. deadlines and parameters
// live in one registered-read ram of EVENTS entries, armed bits and the cache
// in flops. a schedule or cancel that does not disturb the cached owner goes
// from accept straight to the status transaction. a schedule that moves the
// owner later, or a cancel of the owner, triggers a rescan: the ram is read
// once per entry, pipelined one entry per cycle. an advance first passes a
// check state that compares the new time against the cached deadline; if
// something is due it runs the same scan, which also fires and disarms due
// entries in ascending id order, one fired transaction each, and the scan
// pauses while a due entry meets a full output register. every item ends
// with a status transaction carrying the new earliest deadline. the output
// is a single register, so a new item can be accepted while the last status
// transaction waits for m_ready. no clearing pass is needed after reset.
module event_deadline_scheduler_unit #(
    parameter int EVENTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [edsu_pkg::FUNC_W-1:0]    s_func,
    input  logic [edsu_pkg::ID_W-1:0]      s_event_id,
    input  logic [edsu_pkg::TIME_W-1:0]    s_deadline,
    input  logic [edsu_pkg::PARAM_W-1:0]   s_event_param,
    input  logic [edsu_pkg::STEP_W-1:0]    s_time_step,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_kind,
    output logic [edsu_pkg::ID_W-1:0]      m_fired_id,
    output logic [edsu_pkg::PARAM_W-1:0]   m_fired_param,
    output logic [edsu_pkg::TIME_W-1:0]    m_fired_deadline,
    output logic [edsu_pkg::TIME_W-1:0]    m_earliest_dl,
    output logic [edsu_pkg::NEXT_EV_W-1:0] m_next_event,
    output logic                           m_last
);

    import edsu_pkg::*;

    localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int CNT_W = $clog2(EVENTS + 1);
    localparam logic [CNT_W-1:0]     CNT_END  = CNT_W'(EVENTS);
    localparam logic [NEXT_EV_W-1:0] NO_EVENT = NEXT_EV_W'(EVENTS);

    // control state
    state_t                 state_reg, state_next;
    logic                   fire_mode_reg, fire_mode_next;
    logic [EVENTS-1:0]      armed_reg, armed_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [TIME_W-1:0]      early_dl_reg, early_dl_next;
    logic [NEXT_EV_W-1:0]   early_ev_reg, early_ev_next;

    // scan pipeline: read address counter and the entry under evaluation
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]       ev_idx_reg, ev_idx_next;
    logic [TIME_W-1:0]      best_dl_reg, best_dl_next;
    logic [NEXT_EV_W-1:0]   best_ev_reg, best_ev_next;

    // output register
    logic                   out_vld_reg, out_vld_next;
    logic                   out_kind_reg, out_kind_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [PARAM_W-1:0]     out_prm_reg, out_prm_next;
    logic [TIME_W-1:0]      out_dl_reg, out_dl_next;
    logic [TIME_W-1:0]      out_nd_reg, out_nd_next;
    logic [NEXT_EV_W-1:0]   out_ne_reg, out_ne_next;
    logic                   out_last_reg, out_last_next;

    // ram ports
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    entry_t                 ram_rdata;

    logic                   accept;
    logic                   out_free;
    logic                   id_ok;
    logic [IDX_W-1:0]       s_idx;
    logic                   id_armed;
    logic                   is_owner;
    logic                   ev_armed;
    logic                   ev_due;
    logic                   ev_fire;
    logic                   ev_better;
    logic                   stall;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_vld_reg || m_ready;

    // ids beyond the table are ignored
    assign id_ok    = ({28'd0, s_event_id} < 32'(EVENTS));
    assign s_idx    = IDX_W'(s_event_id);
    assign id_armed = id_ok && armed_reg[s_idx];
    assign is_owner = id_armed && (early_ev_reg == NEXT_EV_W'(s_event_id));

    // schedule writes the entry at accept; scans only start afterwards
    assign ram_we          = accept && (func_t'(s_func) == FUNC_SCHEDULE) && id_ok;
    assign ram_waddr       = s_idx;
    assign ram_wdata.deadline = s_deadline;
    assign ram_wdata.param    = s_event_param;
    assign ram_raddr       = rd_cnt_reg[IDX_W-1:0];

    // evaluation of the entry whose read data is now present
    assign ev_armed  = ev_vld_reg && armed_reg[ev_idx_reg];
    assign ev_due    = fire_mode_reg && (ram_rdata.deadline <= time_reg);
    assign ev_fire   = ev_armed && ev_due;
    assign ev_better = ev_armed && !ev_due && (ram_rdata.deadline < best_dl_reg);
    assign stall     = ev_fire && !out_free;

    edsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EVENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        fire_mode_next = fire_mode_reg;
        armed_next     = armed_reg;
        time_next      = time_reg;
        early_dl_next  = early_dl_reg;
        early_ev_next  = early_ev_reg;
        rd_cnt_next    = rd_cnt_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        best_dl_next   = best_dl_reg;
        best_ev_next   = best_ev_reg;
        out_vld_next   = out_vld_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_prm_next   = out_prm_reg;
        out_dl_next    = out_dl_reg;
        out_nd_next    = out_nd_reg;
        out_ne_next    = out_ne_reg;
        out_last_next  = out_last_reg;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // default target for anything that needs no scan
                state_next   = ST_STAT;
                rd_cnt_next  = '0;
                ev_vld_next  = 1'b0;
                best_dl_next = NO_DEADLINE;
                best_ev_next = NO_EVENT;
                if (accept) begin
                    unique case (func_t'(s_func))
                        FUNC_SCHEDULE: begin
                            if (id_ok) begin
                                armed_next[s_idx] = 1'b1;
                                if (s_deadline < early_dl_reg) begin
                                    early_dl_next = s_deadline;
                                    early_ev_next = NEXT_EV_W'(s_event_id);
                                end else if (is_owner && (s_deadline > early_dl_reg)) begin
                                    // owner moved later: find the new earliest
                                    fire_mode_next = 1'b0;
                                    state_next     = ST_SCAN;
                                end
                            end
                        end
                        FUNC_CANCEL: begin
                            if (id_armed) begin
                                armed_next[s_idx] = 1'b0;
                                if (is_owner) begin
                                    fire_mode_next = 1'b0;
                                    state_next     = ST_SCAN;
                                end
                            end
                        end
                        FUNC_ADVANCE: begin
                            time_next  = time_reg + {32'd0, s_time_step};
                            state_next = ST_CHECK;
                        end
                        default: begin
                            // reserved code: status only
                        end
                    endcase
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK: begin
                // anything due at the new time
                fire_mode_next = 1'b1;
                state_next     = (time_reg >= early_dl_reg) ? ST_SCAN : ST_STAT;
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (ev_fire) begin
                        armed_next[ev_idx_reg] = 1'b0;
                        out_vld_next  = 1'b1;
                        out_kind_next = KIND_FIRED;
                        out_id_next   = ID_W'(ev_idx_reg);
                        out_prm_next  = ram_rdata.param;
                        out_dl_next   = ram_rdata.deadline;
                        out_nd_next   = '0;
                        out_ne_next   = '0;
                        out_last_next = 1'b0;
                    end
                    if (ev_better) begin
                        best_dl_next = ram_rdata.deadline;
                        best_ev_next = NEXT_EV_W'(ev_idx_reg);
                    end
                    if (rd_cnt_reg != CNT_END) begin
                        ram_re      = 1'b1;
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                        ev_vld_next = 1'b1;
                        ev_idx_next = rd_cnt_reg[IDX_W-1:0];
                    end else begin
                        ev_vld_next = 1'b0;
                        if (!ev_vld_reg) begin
                            // every entry evaluated: commit the new earliest
                            early_dl_next = best_dl_reg;
                            early_ev_next = best_ev_reg;
                            state_next    = ST_STAT;
                        end
                    end
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_STATUS;
                    out_id_next   = '0;
                    out_prm_next  = '0;
                    out_dl_next   = '0;
                    out_nd_next   = early_dl_reg;
                    out_ne_next   = early_ev_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            armed_reg    <= '0;
            time_reg     <= '0;
            early_dl_reg <= NO_DEADLINE;
            early_ev_reg <= NO_EVENT;
            ev_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            armed_reg    <= armed_next;
            time_reg     <= time_next;
            early_dl_reg <= early_dl_next;
            early_ev_reg <= early_ev_next;
            ev_vld_reg   <= ev_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        fire_mode_reg <= fire_mode_next;
        rd_cnt_reg    <= rd_cnt_next;
        ev_idx_reg    <= ev_idx_next;
        best_dl_reg   <= best_dl_next;
        best_ev_reg   <= best_ev_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_prm_reg   <= out_prm_next;
        out_dl_reg    <= out_dl_next;
        out_nd_reg    <= out_nd_next;
        out_ne_reg    <= out_ne_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid          = out_vld_reg;
    assign m_kind           = out_kind_reg;
    assign m_fired_id       = out_id_reg;
    assign m_fired_param    = out_prm_reg;
    assign m_fired_deadline = out_dl_reg;
    assign m_earliest_dl    = out_nd_reg;
    assign m_next_event     = out_ne_reg;
    assign m_last           = out_last_reg;

endmodule

// File: hdl/edsu_ram.sv
// generic single write port, single read port ram with registered read
module edsu_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/tb_event_deadline_scheduler_unit.sv
// self-checking testbench for the earliest deadline event timer table
package edsu_tb_pkg;
    import edsu_pkg::*;

    localparam int TABLE_EVENTS = 16;

    typedef struct {
        func_t               func;
        logic [ID_W-1:0]     event_id;
        logic [TIME_W-1:0]   deadline;
        logic [PARAM_W-1:0]  event_param;
        logic [STEP_W-1:0]   time_step;
    } timer_cmd_t;

    typedef struct {
        logic                 kind;
        logic [ID_W-1:0]      fired_id;
        logic [PARAM_W-1:0]   fired_param;
        logic [TIME_W-1:0]    fired_deadline;
        logic [TIME_W-1:0]    earliest_dl;
        logic [NEXT_EV_W-1:0] next_event;
        logic                 last;
    } timer_result_t;

    class event_table_sb;
        logic [TIME_W-1:0]    cur_time;
        logic [TABLE_EVENTS-1:0] armed;
        logic [TIME_W-1:0]    dl_store [TABLE_EVENTS];
        logic [PARAM_W-1:0]   prm_store[TABLE_EVENTS];
        logic [TIME_W-1:0]    early_dl;
        logic [NEXT_EV_W-1:0] early_ev;
        timer_result_t        outcome_q[$];
        int unsigned          errors;

        function new();
            cur_time = '0;
            armed    = '0;
            early_dl = NO_DEADLINE;
            early_ev = NEXT_EV_W'(TABLE_EVENTS);
            errors   = 0;
            foreach (dl_store[i]) begin
                dl_store[i]  = '0;
                prm_store[i] = '0;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // lowest id wins among equal deadlines
        function void find_earliest();
            early_dl = NO_DEADLINE;
            early_ev = NEXT_EV_W'(TABLE_EVENTS);
            for (int i = 0; i < TABLE_EVENTS; i++) begin
                if (armed[i] && dl_store[i] < early_dl) begin
                    early_dl = dl_store[i];
                    early_ev = NEXT_EV_W'(i);
                end
            end
        endfunction

        // update the table for one accepted command and queue its outcomes
        // (newest at the front, oldest taken from the back)
        function void note_item(timer_cmd_t c);
            logic          was_owner;
            timer_result_t r;
            if (c.func == FUNC_SCHEDULE && c.event_id < TABLE_EVENTS) begin
                was_owner = armed[c.event_id] && early_ev == NEXT_EV_W'(c.event_id);
                dl_store[c.event_id]  = c.deadline;
                prm_store[c.event_id] = c.event_param;
                armed[c.event_id]     = 1'b1;
                if (c.deadline < early_dl) begin
                    early_dl = c.deadline;
                    early_ev = NEXT_EV_W'(c.event_id);
                end else if (was_owner && c.deadline > early_dl) begin
                    find_earliest();
                end
            end else if (c.func == FUNC_CANCEL && c.event_id < TABLE_EVENTS) begin
                if (armed[c.event_id]) begin
                    armed[c.event_id] = 1'b0;
                    if (early_ev == NEXT_EV_W'(c.event_id))
                        find_earliest();
                end
            end else if (c.func == FUNC_ADVANCE) begin
                cur_time = cur_time + TIME_W'(c.time_step);
                if (cur_time >= early_dl) begin
                    // fire due entries in ascending id order, rebuild the cache
                    for (int i = 0; i < TABLE_EVENTS; i++) begin
                        if (armed[i] && dl_store[i] <= cur_time) begin
                            armed[i]         = 1'b0;
                            r.kind           = KIND_FIRED;
                            r.fired_id       = ID_W'(i);
                            r.fired_param    = prm_store[i];
                            r.fired_deadline = dl_store[i];
                            r.earliest_dl    = '0;
                            r.next_event     = '0;
                            r.last           = 1'b0;
                            outcome_q.push_front(r);
                        end
                    end
                    find_earliest();
                end
            end
            r.kind           = KIND_STATUS;
            r.fired_id       = '0;
            r.fired_param    = '0;
            r.fired_deadline = '0;
            r.earliest_dl    = early_dl;
            r.next_event     = early_ev;
            r.last           = 1'b1;
            outcome_q.push_front(r);
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: kind=%0d id=%0d nev=%0d",
                             got.kind, got.fired_id, got.next_event);
                return;
            end
            want = outcome_q.pop_back();
            if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
                got.fired_param !== want.fired_param ||
                got.fired_deadline !== want.fired_deadline ||
                got.earliest_dl !== want.earliest_dl ||
                got.next_event !== want.next_event || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: kind=%0d id=%0d prm=%h fdl=%h ndl=%h nev=%0d last=%0d",
                             want.kind, want.fired_id, want.fired_param, want.fired_deadline,
                             want.earliest_dl, want.next_event, want.last);
                    $display("mismatch got: kind=%0d id=%0d prm=%h fdl=%h ndl=%h nev=%0d last=%0d",
                             got.kind, got.fired_id, got.fired_param, got.fired_deadline,
                             got.earliest_dl, got.next_event, got.last);
                end
            end
        endfunction
    endclass

endpackage

module tb_event_deadline_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import edsu_pkg::*;
    import edsu_tb_pkg::*;

    // total commands driven: about 20 directed, the rest random
    localparam int CMD_TARGET = 250;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [FUNC_W-1:0]      s_func        = '0;
    logic [ID_W-1:0]        s_event_id    = '0;
    logic [TIME_W-1:0]      s_deadline    = '0;
    logic [PARAM_W-1:0]     s_event_param = '0;
    logic [STEP_W-1:0]      s_time_step   = '0;

    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_kind;
    logic [ID_W-1:0]        m_fired_id;
    logic [PARAM_W-1:0]     m_fired_param;
    logic [TIME_W-1:0]      m_fired_deadline;
    logic [TIME_W-1:0]      m_earliest_dl;
    logic [NEXT_EV_W-1:0]   m_next_event;
    logic                   m_last;

    event_table_sb sb = new();

    int  items_sent   = 0;
    bit  no_gaps      = 1'b0;   // sender never idles while set
    bit  steady_ready = 1'b0;   // receiver never stalls while set
    int  ready_hold   = 0;

    always #10 aclk = ~aclk;

    event_deadline_scheduler_unit #(
        .EVENTS           (TABLE_EVENTS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_event_id       (s_event_id),
        .s_deadline       (s_deadline),
        .s_event_param    (s_event_param),
        .s_time_step      (s_time_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fired_id       (m_fired_id),
        .m_fired_param    (m_fired_param),
        .m_fired_deadline (m_fired_deadline),
        .m_earliest_dl    (m_earliest_dl),
        .m_next_event     (m_next_event),
        .m_last           (m_last)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic timer_cmd_t mk_cmd(func_t f, logic [ID_W-1:0] id,
                                          logic [TIME_W-1:0] dl,
                                          logic [PARAM_W-1:0] prm,
                                          logic [STEP_W-1:0] step);
        timer_cmd_t c;
        c.func        = f;
        c.event_id    = id;
        c.deadline    = dl;
        c.event_param = prm;
        c.time_step   = step;
        return c;
    endfunction

    // result side: stall pattern changes at the falling edge
    always @(negedge aclk) begin
        int stall;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady_ready) begin
            m_ready <= 1'b1;
        end else begin
            stall = pick_gap();
            if (stall == 0) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= stall - 1;
            end
        end
    end

    // result side: every accepted transaction goes to the scoreboard
    always @(posedge aclk) begin
        timer_result_t got;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            got.kind           = m_kind;
            got.fired_id       = m_fired_id;
            got.fired_param    = m_fired_param;
            got.fired_deadline = m_fired_deadline;
            got.earliest_dl    = m_earliest_dl;
            got.next_event     = m_next_event;
            got.last           = m_last;
            sb.check_result(got);
        end
    end

    // present one command at a falling edge, hold it until accepted,
    // then maybe idle the sender for a while; returns at a falling edge
    task automatic send_cmd(input timer_cmd_t c);
        int gap;
        s_valid       <= 1'b1;
        s_func        <= c.func;
        s_event_id    <= c.event_id;
        s_deadline    <= c.deadline;
        s_event_param <= c.event_param;
        s_time_step   <= c.time_step;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        sb.note_item(c);
        items_sent++;
        @(negedge aclk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // watchdog, well above the slowest legal run
    initial begin
        #20_000_000;
        $display("[event_deadline_scheduler_unit] ERROR");
        $finish;
    end

    initial begin
        int          pick;
        int          n;
        bit          paused_once;
        logic [TIME_W-1:0] base;
        timer_cmd_t  c;

        paused_once = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty table, ties, owner moves, cancels, unused code,
        // extreme deadlines, params and steps
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           '0));
        send_cmd(mk_cmd(FUNC_CANCEL,   4'd3,  '0,          '0,           '0));
        // all-ones deadline is armed but can never own the cache
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd0,  NO_DEADLINE, '0,           '0));
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd15, 64'd100,     32'hFFFF_FFFF, '0));
        // equal deadline does not steal ownership
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd5,  64'd100,     32'h5555_5555, '0));
        // owner rescheduled to the same deadline keeps it
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd15, 64'd100,     32'hAAAA_AAAA, '0));
        // owner moved later forces a rescan
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd15, 64'd200,     32'h1234_5678, '0));
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd2,  64'd50,      32'h0000_0002, '0));
        // cancel of the owner, then of an unarmed slot
        send_cmd(mk_cmd(FUNC_CANCEL,   4'd2,  '0,          '0,           '0));
        send_cmd(mk_cmd(FUNC_CANCEL,   4'd7,  '0,          '0,           '0));
        send_cmd(mk_cmd(FUNC_RESERVED, 4'd5,  64'd1,       32'hDEAD_BEEF, 32'd1000));
        // nothing due yet, then exactly due
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           32'd99));
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           32'd0));
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           32'd1));
        // past deadline and a tie, then a maximum step fires them all
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd9,  64'd0,       32'h0000_0009, '0));
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd10, 64'd150,     32'h0000_000A, '0));
        send_cmd(mk_cmd(FUNC_SCHEDULE, 4'd11, 64'd150,     32'h0000_000B, '0));
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           32'hFFFF_FFFF));
        // cancel of an armed entry that does not own the cache
        send_cmd(mk_cmd(FUNC_CANCEL,   4'd0,  '0,          '0,           '0));
        send_cmd(mk_cmd(FUNC_ADVANCE,  4'd0,  '0,          '0,           32'd0));

        drain_results();

        while (items_sent < CMD_TARGET) begin
            // a window with neither side idling
            no_gaps      = (items_sent >= 180 && items_sent < 220);
            steady_ready = no_gaps;
            if (!paused_once && items_sent >= 140) begin
                drain_results();
                paused_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // a few near-future schedules, maybe an owner change, then an advance
                n = $urandom_range(1, 5);
                repeat (n) begin
                    base = sb.cur_time + 64'(100 * $urandom_range(0, 30));
                    send_cmd(mk_cmd(FUNC_SCHEDULE, ID_W'($urandom_range(0, 15)),
                                    base, $urandom, '0));
                end
                if ($urandom_range(0, 9) < 3 && sb.early_ev < TABLE_EVENTS) begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(mk_cmd(FUNC_CANCEL, ID_W'(sb.early_ev), '0, '0, '0));
                    else
                        send_cmd(mk_cmd(FUNC_SCHEDULE, ID_W'(sb.early_ev),
                                        sb.early_dl + 64'($urandom_range(0, 500)),
                                        $urandom, '0));
                end
                send_cmd(mk_cmd(FUNC_ADVANCE, ID_W'($urandom_range(0, 15)), '0, '0,
                                STEP_W'($urandom_range(0, 2000))));
            end else if (pick < 72) begin
                // fill every slot close to now, then fire the lot in one advance
                for (int i = 0; i < TABLE_EVENTS; i++)
                    send_cmd(mk_cmd(FUNC_SCHEDULE, ID_W'(i),
                                    sb.cur_time + 64'($urandom_range(0, 15)),
                                    $urandom, '0));
                send_cmd(mk_cmd(FUNC_ADVANCE, '0, '0, '0,
                                STEP_W'($urandom_range(15, 40))));
            end else begin
                // noise: any code, any slot, full-range fields
                c.func        = func_t'(FUNC_W'($urandom_range(0, 3)));
                c.event_id    = ID_W'($urandom_range(0, 15));
                c.event_param = $urandom;
                case ($urandom_range(0, 3))
                    0: c.deadline = NO_DEADLINE;
                    1: c.deadline = sb.cur_time - 64'($urandom_range(0, 100));
                    default: c.deadline = {$urandom, $urandom};
                endcase
                if ($urandom_range(0, 1) == 0)
                    c.time_step = $urandom;
                else
                    c.time_step = STEP_W'($urandom_range(0, 50));
                send_cmd(c);
            end
        end

        // everything sent: wait for the tail, then give strays a chance to show
        no_gaps      = 1'b0;
        steady_ready = 1'b0;
        drain_results();
        repeat (2 * TABLE_EVENTS + 8) @(negedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("[event_deadline_scheduler_unit] OK");
        else
            $display("[event_deadline_scheduler_unit] ERROR");
        $finish;
    end

endmodule
